### rtl/ndpm_pkg.sv
package ndpm_pkg;

  localparam int INDEX_W = 6;
  localparam int DATA_W  = 32;
  localparam int REG_W   = 17;
  localparam int ACC_W   = 48;
  localparam int WIDE_W  = 66;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  localparam logic [1:0] MODE_LOAD    = 2'd0;
  localparam logic [1:0] MODE_FORWARD = 2'd1;
  localparam logic [1:0] MODE_UPDATE  = 2'd2;

  localparam logic [1:0] OP_LOAD    = 2'd0;
  localparam logic [1:0] OP_FORWARD = 2'd1;
  localparam logic [1:0] OP_UPDATE  = 2'd2;
  localparam logic [1:0] OP_NONE    = 2'd3;

  localparam logic KIND_SUM    = 1'b0;
  localparam logic KIND_WEIGHT = 1'b1;

  localparam logic REG_STEP_SIZE       = 1'b0;
  localparam logic REG_MOMENTUM_FACTOR = 1'b1;

  localparam logic [REG_W-1:0] STEP_SIZE_RESET       = 17'd6554;
  localparam logic [REG_W-1:0] MOMENTUM_FACTOR_RESET = 17'd0;

  localparam logic signed [WIDE_W-1:0] S32_MAX = 66'sd2147483647;
  localparam logic signed [WIDE_W-1:0] S32_MIN = -66'sd2147483648;
  localparam logic signed [WIDE_W-1:0] S48_MAX = 66'sd140737488355327;
  localparam logic signed [WIDE_W-1:0] S48_MIN = -66'sd140737488355328;

  typedef struct packed {
    logic [1:0]                op;
    logic [INDEX_W-1:0]        index;
    logic                      in_range;
    logic signed [DATA_W-1:0]  value;
    logic signed [DATA_W-1:0]  error_gradient;
    logic                      last;
  } item_t;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] c;
    c = (v > S32_MAX) ? S32_MAX : ((v < S32_MIN) ? S32_MIN : v);
    return c[DATA_W-1:0];
  endfunction

  function automatic logic sat32_hit(input logic signed [WIDE_W-1:0] v);
    return (v > S32_MAX) || (v < S32_MIN);
  endfunction

  function automatic logic signed [ACC_W-1:0] sat48(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] c;
    c = (v > S48_MAX) ? S48_MAX : ((v < S48_MIN) ? S48_MIN : v);
    return c[ACC_W-1:0];
  endfunction

endpackage

### rtl/ndpm_in_if.sv
interface ndpm_in_if;
  logic                valid;
  logic                ready;
  logic [1:0]          mode;
  logic [5:0]          index;
  logic signed [31:0]  value;
  logic signed [31:0]  error_gradient;
  logic                last;

  modport source (output valid, mode, index, value, error_gradient, last, input ready);
  modport sink (input valid, mode, index, value, error_gradient, last, output ready);
endinterface

### rtl/ndpm_out_if.sv
interface ndpm_out_if;
  logic                valid;
  logic                ready;
  logic                result_kind;
  logic signed [31:0]  result_value;
  logic                saturated;

  modport source (output valid, result_kind, result_value, saturated, input ready);
  modport sink (input valid, result_kind, result_value, saturated, output ready);
endinterface

### rtl/neuron_dot_product_momentum_update_unit.sv
// channel | dir | payload                                  | handshake
// item    | in  | mode, index, value, error_gradient, last | valid/ready
// result  | out | result_kind, result_value, saturated     | valid/ready
// cfg     | in  | cfg_index, cfg_data                      | cfg_we, no wait
//
// the sequencer writes a load from its idle state; a forward transaction passes through MUL and ACC, an
// update through MUL, PROD, DELTA and WRITE, set by the registered memory read and the two chained update multiplies
// sync reset clears the queue, sequencer, accumulator, output register and the
// two registers; weight and delta memories are not cleared
// item ready drops only when the 4-entry queue is full; an emitting transaction
// waits in the sequencer while the output register holds an untaken result
module neuron_dot_product_momentum_update_unit
  import ndpm_pkg::*;
#(
  parameter int MAX_INPUTS = 64,
  parameter int FRAC_BITS  = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [REG_W-1:0] cfg_data,
  ndpm_in_if.sink          item,
  ndpm_out_if.source       result
);

  logic [REG_W-1:0] step_size;
  logic [REG_W-1:0] momentum_factor;

  logic  push;
  item_t push_item;
  logic  queue_full;
  logic  pop;
  logic  head_valid;
  item_t head;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_size       <= STEP_SIZE_RESET;
      momentum_factor <= MOMENTUM_FACTOR_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_STEP_SIZE:       step_size       <= cfg_data;
        REG_MOMENTUM_FACTOR: momentum_factor <= cfg_data;
        default: ;
      endcase
    end
  end

  ndpm_front #(
    .MAX_INPUTS (MAX_INPUTS)
  ) u_front (
    .item       (item),
    .queue_full (queue_full),
    .push       (push),
    .push_item  (push_item)
  );

  ndpm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  ndpm_back #(
    .MAX_INPUTS (MAX_INPUTS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .step_size       (step_size),
    .momentum_factor (momentum_factor),
    .head_valid      (head_valid),
    .head            (head),
    .pop             (pop),
    .result          (result)
  );

endmodule

### rtl/ndpm_front.sv
module ndpm_front
  import ndpm_pkg::*;
#(
  parameter int MAX_INPUTS = 64
) (
  ndpm_in_if.sink item,
  input  logic    queue_full,
  output logic    push,
  output item_t   push_item
);

  logic in_range;

  assign in_range   = ({26'd0, item.index} < 32'(MAX_INPUTS));
  assign item.ready = !queue_full;

  // drop unused modes and out-of-range loads and updates here
  always_comb begin
    push_item.index          = item.index;
    push_item.in_range       = in_range;
    push_item.value          = item.value;
    push_item.error_gradient = item.error_gradient;
    push_item.last           = item.last;
    unique case (item.mode)
      MODE_LOAD:    push_item.op = in_range ? OP_LOAD : OP_NONE;
      MODE_FORWARD: push_item.op = OP_FORWARD;
      MODE_UPDATE:  push_item.op = in_range ? OP_UPDATE : OP_NONE;
      default:      push_item.op = OP_NONE;
    endcase
  end

  assign push = item.valid && item.ready && (push_item.op != OP_NONE);

endmodule

### rtl/ndpm_queue.sv
module ndpm_queue
  import ndpm_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  head_valid,
  output item_t head
);

  item_t             slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full       = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

### rtl/ndpm_back.sv
module ndpm_back
  import ndpm_pkg::*;
#(
  parameter int MAX_INPUTS = 64,
  parameter int FRAC_BITS  = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [REG_W-1:0] step_size,
  input  logic [REG_W-1:0] momentum_factor,
  input  logic             head_valid,
  input  item_t            head,
  output logic             pop,
  ndpm_out_if.source       result
);

  localparam int ADDR_W = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
  localparam logic signed [DATA_W-1:0] ONE = DATA_W'(1) << FRAC_BITS;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MUL   = 3'd1;
  localparam logic [2:0] ST_ACC   = 3'd2;
  localparam logic [2:0] ST_PROD  = 3'd3;
  localparam logic [2:0] ST_DELTA = 3'd4;
  localparam logic [2:0] ST_WRITE = 3'd5;

  logic signed [DATA_W-1:0] wmem [MAX_INPUTS];
  logic signed [DATA_W-1:0] dmem [MAX_INPUTS];

  logic [2:0]                  state;
  logic signed [ACC_W-1:0]     acc;
  item_t                       cur;
  logic signed [DATA_W-1:0]    rd_w;
  logic signed [DATA_W-1:0]    rd_d;
  logic signed [2*DATA_W-1:0]  prod;
  logic signed [REG_W+DATA_W:0] traw;
  logic signed [REG_W+DATA_W:0] mraw;
  logic signed [DATA_W-1:0]    delta;

  logic                        res_valid;
  logic                        res_kind;
  logic signed [DATA_W-1:0]    res_value;
  logic                        res_sat;

  logic [ADDR_W+INDEX_W-1:0]   head_ext;
  logic [ADDR_W+INDEX_W-1:0]   cur_ext;
  logic [ADDR_W-1:0]           head_addr;
  logic [ADDR_W-1:0]           cur_addr;
  logic [ADDR_W-1:0]           wr_addr;
  logic                        wr_en;
  logic signed [DATA_W-1:0]    wr_weight;
  logic signed [DATA_W-1:0]    wr_delta;

  logic                        out_free;
  logic                        emit_weight;
  logic                        emit_sum;
  logic                        acc_go;
  logic signed [DATA_W-1:0]    x;
  logic signed [DATA_W-1:0]    t;
  logic signed [WIDE_W-1:0]    wsum;
  logic signed [DATA_W-1:0]    wnew;
  logic signed [ACC_W-1:0]     acc_new;
  logic signed [WIDE_W-1:0]    acc_wide;

  assign head_ext  = {{ADDR_W{1'b0}}, head.index};
  assign cur_ext   = {{ADDR_W{1'b0}}, cur.index};
  assign head_addr = head_ext[ADDR_W-1:0];
  assign cur_addr  = cur_ext[ADDR_W-1:0];

  assign out_free    = !res_valid || result.ready;
  assign pop         = (state == ST_IDLE) && head_valid;
  assign emit_weight = (state == ST_WRITE) && out_free;
  assign emit_sum    = (state == ST_ACC) && cur.last && out_free;
  assign acc_go      = (state == ST_ACC) && (!cur.last || out_free);

  assign x = (cur.index == '0) ? ONE : cur.value;
  assign t = sat32(WIDE_W'(traw >>> FRAC_BITS));

  assign wsum = WIDE_W'(rd_w) + WIDE_W'(delta);
  assign wnew = sat32(wsum);

  // forward accumulate: bias entry loads, other in-range entries add the scaled product, out-of-range ones leave it
  always_comb begin
    acc_new = acc;
    if (cur.in_range) begin
      if (cur.index == '0) begin
        acc_new = ACC_W'(rd_w);
      end else begin
        acc_new = sat48(WIDE_W'(acc) + WIDE_W'(prod >>> FRAC_BITS));
      end
    end
  end
  assign acc_wide = WIDE_W'(acc_new);

  assign wr_en     = (pop && (head.op == OP_LOAD)) || emit_weight;
  assign wr_addr   = pop ? head_addr : cur_addr;
  assign wr_weight = pop ? head.value : wnew;
  assign wr_delta  = pop ? '0 : delta;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      wmem[wr_addr] <= wr_weight;
      dmem[wr_addr] <= wr_delta;
    end
    if (pop) begin
      rd_w <= wmem[head_addr];
      rd_d <= dmem[head_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      acc       <= '0;
      res_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (pop && (head.op != OP_LOAD)) begin
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          state <= (cur.op == OP_UPDATE) ? ST_PROD : ST_ACC;
        end
        ST_ACC: begin
          if (acc_go) begin
            acc   <= cur.last ? '0 : acc_new;
            state <= ST_IDLE;
          end
        end
        ST_PROD: begin
          state <= ST_DELTA;
        end
        ST_DELTA: begin
          state <= ST_WRITE;
        end
        ST_WRITE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      if (emit_weight || emit_sum) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
    if (state == ST_MUL) begin
      prod <= rd_w * cur.value;
      traw <= $signed({1'b0, step_size}) * x;
      mraw <= $signed({1'b0, momentum_factor}) * rd_d;
    end
    if (state == ST_PROD) begin
      prod <= t * cur.error_gradient;
    end
    if (state == ST_DELTA) begin
      delta <= sat32(WIDE_W'(prod >>> FRAC_BITS) + WIDE_W'(mraw >>> FRAC_BITS));
    end
    if (emit_weight) begin
      res_kind  <= KIND_WEIGHT;
      res_value <= wnew;
      res_sat   <= sat32_hit(wsum);
    end else if (emit_sum) begin
      res_kind  <= KIND_SUM;
      res_value <= sat32(acc_wide);
      res_sat   <= sat32_hit(acc_wide);
    end
  end

  assign result.valid        = res_valid;
  assign result.result_kind  = res_kind;
  assign result.result_value = res_value;
  assign result.saturated    = res_sat;

endmodule
